/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge and held off
// during reset. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr holds at every edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/osh_pkg.sv */
// ----------------------------------------------------------------------------
// osh_pkg
// Shared types, register map and split multiplier helpers for the offset
// polynomial string hash.
// ----------------------------------------------------------------------------
package osh_pkg;

	localparam int HASH_WIDTH_DEF = 64;
	localparam int CFG_ADDR_W     = 5;
	localparam int CFG_DATA_W     = 64;

	typedef enum logic [1:0] {
		REG_BASE         = 2'd0,
		REG_START_INDEX  = 2'd1,
		REG_SIGNED_CHARS = 2'd2
	} reg_idx_t;

	// partial products of a 64x64 multiply, low 64 bits only
	typedef struct packed {
		logic [63:0] ll;
		logic [31:0] lh;
		logic [31:0] hl;
	} mul_pp_t;

	// power unit status seen by the datapath
	typedef struct packed {
		logic busy;
		logic load;
	} pwr_ctl_t;

	function automatic mul_pp_t mul_part(input logic [63:0] a, input logic [63:0] b);
		mul_pp_t p;
		p.ll = 64'(a[31:0]) * 64'(b[31:0]);
		p.lh = a[31:0] * b[63:32];
		p.hl = a[63:32] * b[31:0];
		return p;
	endfunction

	function automatic logic [63:0] mul_join(input mul_pp_t p);
		logic [31:0] cross_sum;
		cross_sum = p.lh + p.hl;
		return p.ll + {cross_sum, 32'h0};
	endfunction

endpackage

/* rtl/osh_if.sv */
// ----------------------------------------------------------------------------
// osh_if
// Valid/ready channels: string bytes in, hash results out.
// ----------------------------------------------------------------------------
interface osh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface osh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink   (input valid, input hash_value, output ready);
endinterface

/* rtl/offset_polynomial_string_hash.sv */
// ----------------------------------------------------------------------------
// offset_polynomial_string_hash
// Weighted byte sum modulo 2^HASH_WIDTH, byte i weighted by
// base^(start_index+i), with an APB-style register port.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the power unit is idle and the result
// buffer has space. Latency: the hash is offered the cycle after the last
// byte's transfer if no earlier hash still waits in the result buffer.
// After a base or start_index write, input stalls while the power unit runs
// (one shared multiplier, one product at a time).
// Reset: registers to base 0, start_index 0, signed_chars 1; start power 1.
// ----------------------------------------------------------------------------
module offset_polynomial_string_hash import osh_pkg::*; #(
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	osh_byte_if.sink              in_ch,
	osh_hash_if.source            out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [63:0] base_q;
	logic [63:0] start_q;
	logic        signed_q;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	logic        pwr_start;
	logic [63:0] base_nx;
	logic [63:0] start_nx;

	pwr_ctl_t              ctl;
	logic [HASH_WIDTH-1:0] sp0;
	logic [HASH_WIDTH-1:0] sp1;
	logic [HASH_WIDTH-1:0] base2;
	logic [HASH_WIDTH-1:0] fix;
	logic                  mid;
	logic [HASH_WIDTH-1:0] head;
	logic                  res_valid;
	logic [HASH_WIDTH-1:0] res_data;
	logic                  res_space;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);

	assign pwr_start = cfg_wr && (cfg_idx == REG_BASE || cfg_idx == REG_START_INDEX);
	assign base_nx   = (cfg_wr && cfg_idx == REG_BASE) ? pwdata : base_q;
	assign start_nx  = (cfg_wr && cfg_idx == REG_START_INDEX) ? pwdata : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			start_q  <= '0;
			signed_q <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BASE:         base_q   <= pwdata;
				REG_START_INDEX:  start_q  <= pwdata;
				REG_SIGNED_CHARS: signed_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BASE:         prdata = base_q;
			REG_START_INDEX:  prdata = start_q;
			REG_SIGNED_CHARS: prdata = {63'h0, signed_q};
			default:          prdata = '0;
		endcase
	end

	osh_pwr_unit #(.HASH_WIDTH(HASH_WIDTH)) u_pwr (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pwr_start),
		.base_nx  (base_nx),
		.start_nx (start_nx),
		.base     (base_q[HASH_WIDTH-1:0]),
		.mid      (mid),
		.head     (head),
		.ctl      (ctl),
		.sp0      (sp0),
		.sp1      (sp1),
		.base2    (base2),
		.fix      (fix)
	);

	osh_hash_core #(.HASH_WIDTH(HASH_WIDTH)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.signed_chars (signed_q),
		.ctl          (ctl),
		.sp0          (sp0),
		.sp1          (sp1),
		.base2        (base2),
		.fix          (fix),
		.res_space    (res_space),
		.mid          (mid),
		.head         (head),
		.res_valid    (res_valid),
		.res_data     (res_data)
	);

	osh_out_fifo #(.HASH_WIDTH(HASH_WIDTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.space     (res_space),
		.out_ch    (out_ch)
	);

endmodule

/* rtl/osh_pwr_unit.sv */
// ----------------------------------------------------------------------------
// osh_pwr_unit
// Sequential square-and-multiply for base^start_index, then base^2,
// start_power*base and, mid-string, a re-based next power. One shared
// multiplier; each product is launched in an A state, taken in its B state.
// ----------------------------------------------------------------------------
module osh_pwr_unit import osh_pkg::*; #(
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           base_nx,
	input  logic [63:0]           start_nx,
	input  logic [HASH_WIDTH-1:0] base,
	input  logic                  mid,
	input  logic [HASH_WIDTH-1:0] head,
	output pwr_ctl_t              ctl,
	output logic [HASH_WIDTH-1:0] sp0,
	output logic [HASH_WIDTH-1:0] sp1,
	output logic [HASH_WIDTH-1:0] base2,
	output logic [HASH_WIDTH-1:0] fix
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC_A, ST_ACC_B, ST_SQ_A, ST_SQ_B, ST_B2_A, ST_B2_B,
		ST_SP1_A, ST_SP1_B, ST_FIX_A, ST_FIX_B, ST_DONE
	} state_t;

	state_t                state_q;
	logic [HASH_WIDTH-1:0] acc_q;
	logic [HASH_WIDTH-1:0] sq_q;
	logic [63:0]           exp_q;
	logic [HASH_WIDTH-1:0] sp1_q;
	logic [HASH_WIDTH-1:0] b2_q;
	logic [HASH_WIDTH-1:0] fix_q;
	mul_pp_t               pp_s1;

	logic [HASH_WIDTH-1:0] op_a;
	logic [HASH_WIDTH-1:0] op_b;
	logic                  mul_launch;
	logic [HASH_WIDTH-1:0] prod;
	logic [62:0]           exp_rest;

	always_comb begin
		op_a       = acc_q;
		op_b       = sq_q;
		mul_launch = 1'b1;
		case (state_q)
			ST_ACC_A: begin
				op_a = acc_q;
				op_b = sq_q;
			end
			ST_SQ_A: begin
				op_a = sq_q;
				op_b = sq_q;
			end
			ST_B2_A: begin
				op_a = base;
				op_b = base;
			end
			ST_SP1_A: begin
				op_a = acc_q;
				op_b = base;
			end
			ST_FIX_A: begin
				op_a = head;
				op_b = base;
			end
			default: begin
				mul_launch = 1'b0;
			end
		endcase
	end

	assign prod     = HASH_WIDTH'(mul_join(pp_s1));
	assign exp_rest = exp_q[63:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= HASH_WIDTH'(1);
			sq_q    <= '0;
			exp_q   <= '0;
			sp1_q   <= '0;
			b2_q    <= '0;
			fix_q   <= '0;
			pp_s1   <= '0;
		end else if (start) begin
			acc_q <= HASH_WIDTH'(1);
			sq_q  <= base_nx[HASH_WIDTH-1:0];
			exp_q <= start_nx;
			if (start_nx == 64'h0) begin
				state_q <= ST_B2_A;
			end else if (start_nx[0]) begin
				state_q <= ST_ACC_A;
			end else begin
				state_q <= ST_SQ_A;
			end
		end else begin
			if (mul_launch) begin
				pp_s1 <= mul_part(64'(op_a), 64'(op_b));
			end
			case (state_q)
				ST_ACC_A: state_q <= ST_ACC_B;
				ST_ACC_B: begin
					acc_q   <= prod;
					state_q <= ST_SQ_A;
				end
				ST_SQ_A: state_q <= ST_SQ_B;
				ST_SQ_B: begin
					sq_q  <= prod;
					exp_q <= {1'b0, exp_rest};
					// stop once no set bit remains above this one
					if (exp_rest == 63'h0) begin
						state_q <= ST_B2_A;
					end else if (exp_rest[0]) begin
						state_q <= ST_ACC_A;
					end else begin
						state_q <= ST_SQ_A;
					end
				end
				ST_B2_A: state_q <= ST_B2_B;
				ST_B2_B: begin
					b2_q    <= prod;
					state_q <= ST_SP1_A;
				end
				ST_SP1_A: state_q <= ST_SP1_B;
				ST_SP1_B: begin
					sp1_q   <= prod;
					state_q <= mid ? ST_FIX_A : ST_DONE;
				end
				ST_FIX_A: state_q <= ST_FIX_B;
				ST_FIX_B: begin
					fix_q   <= prod;
					state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ctl.busy = (state_q != ST_IDLE);
	assign ctl.load = (state_q == ST_DONE);
	assign sp0      = acc_q;
	assign sp1      = sp1_q;
	assign base2    = b2_q;
	assign fix      = fix_q;

endmodule

/* rtl/osh_hash_core.sv */
// ----------------------------------------------------------------------------
// osh_hash_core
// Per-byte multiply-accumulate with a two-entry power queue. The power two
// bytes ahead comes from a registered split multiply by base^2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module osh_hash_core import osh_pkg::*; #(
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	osh_byte_if.sink              in_ch,
	input  logic                  signed_chars,
	input  pwr_ctl_t              ctl,
	input  logic [HASH_WIDTH-1:0] sp0,
	input  logic [HASH_WIDTH-1:0] sp1,
	input  logic [HASH_WIDTH-1:0] base2,
	input  logic [HASH_WIDTH-1:0] fix,
	input  logic                  res_space,
	output logic                  mid,
	output logic [HASH_WIDTH-1:0] head,
	output logic                  res_valid,
	output logic [HASH_WIDTH-1:0] res_data
);

	logic [HASH_WIDTH-1:0] sum_q;
	logic [HASH_WIDTH-1:0] q0_q;
	logic [HASH_WIDTH-1:0] q1_q;
	logic                  q1_v_q;
	logic                  mid_q;
	mul_pp_t               pp_s1;
	logic                  mul_v_s1;

	logic                  acc;
	logic                  launch;
	logic [HASH_WIDTH+7:0] mac_full;
	logic [HASH_WIDTH-1:0] neg_term;
	logic [HASH_WIDTH-1:0] sum_next;
	logic [HASH_WIDTH-1:0] push_val;

	assign in_ch.ready = !ctl.busy && res_space;
	assign acc         = in_ch.valid && in_ch.ready;
	assign launch      = acc && !in_ch.last_byte;

	// signed char weighs as byte - 256
	assign mac_full = q0_q * in_ch.byte_value;
	assign neg_term = (signed_chars && in_ch.byte_value[7]) ? HASH_WIDTH'({q0_q, 8'h00}) : '0;
	assign sum_next = sum_q + mac_full[HASH_WIDTH-1:0] - neg_term;
	assign push_val = HASH_WIDTH'(mul_join(pp_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			q0_q     <= HASH_WIDTH'(1);
			q1_q     <= '0;
			q1_v_q   <= 1'b1;
			mid_q    <= 1'b0;
			pp_s1    <= '0;
			mul_v_s1 <= 1'b0;
		end else begin
			mul_v_s1 <= launch;
			if (launch) begin
				pp_s1 <= mul_part(64'(q0_q), 64'(base2));
			end
			if (ctl.load) begin
				if (mid_q) begin
					q1_q <= fix;
				end else begin
					q0_q <= sp0;
					q1_q <= sp1;
				end
				q1_v_q <= 1'b1;
			end else if (acc && in_ch.last_byte) begin
				// string done: restart at the start power
				sum_q  <= '0;
				mid_q  <= 1'b0;
				q0_q   <= sp0;
				q1_q   <= sp1;
				q1_v_q <= 1'b1;
			end else if (acc) begin
				sum_q <= sum_next;
				mid_q <= 1'b1;
				if (q1_v_q) begin
					q0_q   <= q1_q;
					q1_v_q <= 1'b0;
				end else begin
					q0_q   <= push_val;
					q1_v_q <= 1'b0;
				end
			end else if (mul_v_s1) begin
				q1_q   <= push_val;
				q1_v_q <= 1'b1;
			end
		end
	end

	assign mid       = mid_q;
	assign head      = q0_q;
	assign res_valid = acc && in_ch.last_byte;
	assign res_data  = sum_next;

	`ASSERT_ALWAYS(a_one_power_ahead, clk, arst_n, q1_v_q != mul_v_s1,
		"next power neither queued nor in flight")
	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, acc && in_ch.last_byte,
		!mid_q && (sum_q == '0), "sum not cleared after last byte")
	`ASSERT_NEXT(a_chain_launch, clk, arst_n, acc && !in_ch.last_byte, mul_v_s1,
		"power product not launched on mid-string transfer")

endmodule

/* rtl/osh_out_fifo.sv */
// ----------------------------------------------------------------------------
// osh_out_fifo
// Two-entry result buffer, so a new string can finish while an earlier
// hash still waits on the output.
// ----------------------------------------------------------------------------
module osh_out_fifo import osh_pkg::*; #(
	parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [HASH_WIDTH-1:0] push_data,
	output logic                  space,
	osh_hash_if.source            out_ch
);

	logic [HASH_WIDTH-1:0] e0_q;
	logic [HASH_WIDTH-1:0] e1_q;
	logic                  e0_v_q;
	logic                  e1_v_q;
	logic                  pop;

	assign pop   = out_ch.valid && out_ch.ready;
	assign space = !e1_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_v_q <= 1'b0;
			e1_v_q <= 1'b0;
			e0_q   <= '0;
			e1_q   <= '0;
		end else if (pop) begin
			if (e1_v_q) begin
				e0_q   <= e1_q;
				e1_v_q <= 1'b0;
			end else begin
				e0_q   <= push_data;
				e0_v_q <= push;
			end
		end else if (push) begin
			if (e0_v_q) begin
				e1_q   <= push_data;
				e1_v_q <= 1'b1;
			end else begin
				e0_q   <= push_data;
				e0_v_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid      = e0_v_q;
	assign out_ch.hash_value = 64'(e0_q);

endmodule
